// ===== rtl/core/sfft16_pkg.sv =====
// Package: shared constants and twiddle table for the sliding 16-point FFT.
`timescale 1ns / 1ps
`default_nettype none
package sfft16_pkg;
    localparam int SampleWidthDef = 16;
    localparam int TwFracDef      = 15;
    localparam int OutWidth       = 21;
    localparam int BinBits        = 4;
    localparam int NumBins        = 16;

    // Round a Q1.31 constant to Q1.frac, half up
    function automatic longint q31_to_tw(input longint k, input int frac);
        longint t;
        t = k + (longint'(1) <<< (30 - frac));
        return t >>> (31 - frac);
    endfunction

    // cos(2*pi*m/16) in Q1.frac
    function automatic longint cos16(input int m, input int frac);
        longint c1, h, s1, one;
        longint r;
        c1  = q31_to_tw(64'sd1984016189, frac);
        h   = q31_to_tw(64'sd1518500250, frac);
        s1  = q31_to_tw(64'sd821806413, frac);
        one = longint'(1) <<< frac;
        unique case (m & 15)
            0: r = one;   1: r = c1;   2: r = h;    3: r = s1;
            4: r = 0;     5: r = -s1;  6: r = -h;   7: r = -c1;
            8: r = -one;  9: r = -c1;  10: r = -h;  11: r = -s1;
            12: r = 0;    13: r = s1;  14: r = h;   default: r = c1;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sfft16_front.sv =====
// Front part: window shift register and first radix-4 stage.
`timescale 1ns / 1ps
`default_nettype none
module sfft16_front #(
    parameter int SAMPLE_WIDTH = sfft16_pkg::SampleWidthDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    // first-stage values: 16 real and 16 imaginary, B index 4*i+k
    output logic signed [SAMPLE_WIDTH+1:0]      o_br [16],
    output logic signed [SAMPLE_WIDTH+1:0]      o_bi [16]
);
    import sfft16_pkg::*;
    localparam int BW = SAMPLE_WIDTH + 2;

    logic signed [SAMPLE_WIDTH-1:0] r_win [16];
    logic signed [BW-1:0] n_br [16], n_bi [16];
    logic signed [BW-1:0] r_br [16], r_bi [16];
    logic signed [SAMPLE_WIDTH-1:0] w [16];
    logic r_valid;
    logic take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // Shifted window as it will stand after this request
    always_comb begin
        w[0] = i_sample;
        for (int n = 1; n < 16; n++) w[n] = r_win[n-1];
        for (int i = 0; i < 4; i++) begin
            n_br[4*i+0] = BW'(w[i]) + BW'(w[i+4]) + BW'(w[i+8]) + BW'(w[i+12]);
            n_bi[4*i+0] = '0;
            n_br[4*i+1] = BW'(w[i]) - BW'(w[i+8]);
            n_bi[4*i+1] = BW'(w[i+12]) - BW'(w[i+4]);
            n_br[4*i+2] = BW'(w[i]) - BW'(w[i+4]) + BW'(w[i+8]) - BW'(w[i+12]);
            n_bi[4*i+2] = '0;
            n_br[4*i+3] = BW'(w[i]) - BW'(w[i+8]);
            n_bi[4*i+3] = BW'(w[i+4]) - BW'(w[i+12]);
        end
    end

    // Advance window and register stage results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int n = 0; n < 16; n++) r_win[n] <= '0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                for (int n = 0; n < 16; n++) r_win[n] <= w[n];
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (take) begin
            r_br <= n_br;
            r_bi <= n_bi;
        end
    end

    assign o_valid = r_valid;
    assign o_br    = r_br;
    assign o_bi    = r_bi;
endmodule
`default_nettype wire

// ===== rtl/core/sfft16_back.sv =====
// Back part: queue slot, twiddle products, second stage and bin sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sfft16_back #(
    parameter int SAMPLE_WIDTH      = sfft16_pkg::SampleWidthDef,
    parameter int TWIDDLE_FRAC_BITS = sfft16_pkg::TwFracDef
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [SAMPLE_WIDTH+1:0]    i_br [16],
    input  wire logic signed [SAMPLE_WIDTH+1:0]    i_bi [16],
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [sfft16_pkg::BinBits-1:0]         o_bin,
    output logic signed [sfft16_pkg::OutWidth-1:0] o_re,
    output logic signed [sfft16_pkg::OutWidth-1:0] o_im,
    output logic                                   o_last
);
    import sfft16_pkg::*;
    localparam int BW = SAMPLE_WIDTH + 2;
    localparam int TW = TWIDDLE_FRAC_BITS + 2;
    localparam int PW = BW + TW + 1;
    localparam int CW = PW - TWIDDLE_FRAC_BITS + 1;
    localparam int XW = CW + 2;

    // Queue entry, and twiddled values of the entry being worked
    logic signed [BW-1:0] r_qr [16], r_qi [16];
    logic r_qv;
    logic signed [CW-1:0] r_cr [16], r_ci [16];
    logic r_cv;
    logic [BinBits-1:0] r_cnt;
    logic signed [PW-1:0] pr [16], pi_ [16];
    logic signed [CW-1:0] n_cr [16], n_ci [16];
    logic c_load, q_load, step;
    logic signed [XW-1:0] xr, xi, r0, r1, r2, r3, i0, i1, i2, i3;
    logic [1:0] kk, qq;
    logic signed [OutWidth-1:0] r_ore, r_oim;
    logic [BinBits-1:0] r_obin;
    logic r_ov;

    // Skid of one request between front and back
    assign step   = r_cv && (!r_ov || i_ready);
    assign c_load = r_qv && (!r_cv || (step && r_cnt == BinBits'(NumBins-1)));
    assign o_ready = !r_qv || c_load;
    assign q_load  = i_valid && o_ready;

    // Twiddle multiply and round, one product per entry
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            logic signed [TW-1:0] wr, wi;
            logic signed [PW-1:0] t;
            wr = TW'(cos16((j/4)*(j%4), TWIDDLE_FRAC_BITS));
            wi = TW'(-cos16(((j/4)*(j%4)) + 12, TWIDDLE_FRAC_BITS));
            pr[j]  = PW'(r_qr[j]) * PW'(wr) - PW'(r_qi[j]) * PW'(wi);
            pi_[j] = PW'(r_qi[j]) * PW'(wr) + PW'(r_qr[j]) * PW'(wi);
            t = pr[j] + (PW'(1) <<< (TWIDDLE_FRAC_BITS-1));
            n_cr[j] = CW'(t >>> TWIDDLE_FRAC_BITS);
            t = pi_[j] + (PW'(1) <<< (TWIDDLE_FRAC_BITS-1));
            n_ci[j] = CW'(t >>> TWIDDLE_FRAC_BITS);
        end
    end

    // Second stage for the bin under the counter
    always_comb begin
        kk = r_cnt[1:0];
        qq = r_cnt[3:2];
        r0 = XW'(r_cr[{2'd0, kk}]); i0 = XW'(r_ci[{2'd0, kk}]);
        r1 = XW'(r_cr[{2'd1, kk}]); i1 = XW'(r_ci[{2'd1, kk}]);
        r2 = XW'(r_cr[{2'd2, kk}]); i2 = XW'(r_ci[{2'd2, kk}]);
        r3 = XW'(r_cr[{2'd3, kk}]); i3 = XW'(r_ci[{2'd3, kk}]);
        unique case (qq)
            2'd0: begin xr = r0 + r1 + r2 + r3; xi = i0 + i1 + i2 + i3; end
            2'd1: begin xr = r0 + i1 - r2 - i3; xi = i0 - r1 - i2 + r3; end
            2'd2: begin xr = r0 - r1 + r2 - r3; xi = i0 - i1 + i2 - i3; end
            default: begin xr = r0 - i1 - r2 + i3; xi = i0 + r1 - i2 - r3; end
        endcase
    end

    function automatic logic signed [OutWidth-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi, lo;
        hi = XW'((longint'(1) <<< (OutWidth-1)) - 1);
        lo = -XW'(longint'(1) <<< (OutWidth-1));
        if (v > hi) return OutWidth'(hi);
        if (v < lo) return OutWidth'(lo);
        return OutWidth'(v);
    endfunction

    // Hold queue entry, working copy, counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv  <= 1'b0;
            r_cv  <= 1'b0;
            r_ov  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (q_load) r_qv <= 1'b1;
            else if (c_load) r_qv <= 1'b0;
            if (c_load) r_cv <= 1'b1;
            else if (step && r_cnt == BinBits'(NumBins-1)) r_cv <= 1'b0;
            if (step) r_cnt <= r_cnt + 1'b1;
            if (step) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        if (q_load) begin
            r_qr <= i_br;
            r_qi <= i_bi;
        end
        if (c_load) begin
            r_cr <= n_cr;
            r_ci <= n_ci;
        end
        if (step) begin
            r_ore  <= sat(xr);
            r_oim  <= sat(xi);
            r_obin <= r_cnt;
        end
    end

    assign o_valid = r_ov;
    assign o_re    = r_ore;
    assign o_im    = r_oim;
    assign o_bin   = r_obin;
    assign o_last  = (r_obin == BinBits'(NumBins-1));
endmodule
`default_nettype wire

// ===== rtl/core/sliding_fft16_radix4.sv =====
// Top level of the sliding 16-point radix-4 FFT.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted sample shifts into a 16-entry window (zero after reset, newest in
// slot 0) and produces the 16 DFT bins of the window in natural order, one per
// cycle on the master side while m_axis_tready is high, tlast marking bin 15. The
// back-part sequencer sends at most a single output bin per cycle; the front part
// computes the first radix-4 stage combinationally and registers it, and a one-entry queue
// lets the next sample be taken while the current bins still drain. Bin 0 passes
// the front register, queue slot, twiddled copy and output register in turn.
module sliding_fft16_radix4 #(
    parameter int SAMPLE_WIDTH      = sfft16_pkg::SampleWidthDef,
    parameter int TWIDDLE_FRAC_BITS = sfft16_pkg::TwFracDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // sample
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // bin_index [3:0], bin_re [24:4], bin_im [45:25], zero fill [47:46]
    output logic [47:0]      m_axis_tdata,
    // last_bin
    output logic             m_axis_tlast
);
    import sfft16_pkg::*;

    logic f_valid, b_ready;
    logic signed [SAMPLE_WIDTH+1:0] br [16], bi [16];
    logic [BinBits-1:0] bin;
    logic signed [OutWidth-1:0] re, im;

    sfft16_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sample(s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .o_valid(f_valid), .i_ready(b_ready), .o_br(br), .o_bi(bi)
    );

    sfft16_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(b_ready), .i_br(br), .i_bi(bi),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_bin(bin), .o_re(re), .o_im(im), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, im, re, bin};

    // A valid bin right after a delivered non-final bin is not bin 0
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid
            |-> m_axis_tdata[3:0] != 4'd0)
        else $error("bin sequence broke");
    // tlast only on bin 15
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[3:0] == 4'd15)))
        else $error("tlast misplaced");
endmodule
`default_nettype wire
